// ===== rtl/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// B-spline evaluator package
// Shared types, constants and fixed-point helpers for the evaluator blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bse_pkg;

  localparam int MaxBasisDef = 32;
  localparam int MaxOrderDef = 8;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [5:0]  BasisCountRst  = 6'd8;
  localparam logic [3:0]  SplineOrderRst = 4'd4;
  localparam logic [15:0] LowerYearRst   = 16'd0;
  localparam logic [15:0] UpperYearRst   = 16'hFFFF;

  // One in Q2.30.
  localparam logic signed [31:0] Q30One = 32'sh4000_0000;

  // Quotient bits produced by the divider after the saturation check.
  localparam int DivSteps = 31;

  typedef enum logic [1:0] {
    OP_EVAL = 2'd0,
    OP_KNOT = 2'd1,
    OP_COEF = 2'd2,
    OP_RSVD = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASIS_COUNT  = 2'd0,
    CFG_SPLINE_ORDER = 2'd1,
    CFG_LOWER_YEAR   = 2'd2,
    CFG_UPPER_YEAR   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [5:0]         entry_index;
    logic signed [31:0] entry_value;
    logic [31:0]        query_time;
  } bse_in_t;

  typedef struct packed {
    logic signed [31:0] spline_value;
    logic               out_of_range;
  } bse_out_t;

  typedef struct packed {
    logic [5:0]  basis_count;
    logic [3:0]  spline_order;
    logic [15:0] lower_year;
    logic [15:0] upper_year;
  } bse_cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // (a * b) >> 30, truncated toward zero.
  function automatic logic signed [33:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic        neg;
    logic [31:0] ma, mb;
    logic [63:0] p;
    logic [33:0] m;
    neg = a[31] ^ b[31];
    ma  = a[31] ? 32'(-a) : a;
    mb  = b[31] ? 32'(-b) : b;
    p   = ma * mb;
    m   = p[63:30];
    return neg ? $signed(-m) : $signed(m);
  endfunction

  // Unsigned time against a signed knot, both Q16.16.
  function automatic logic t_ge(input logic [31:0] t, input logic signed [31:0] kn);
    logic signed [33:0] ts, ks;
    ts = $signed({2'b00, t});
    ks = 34'(kn);
    return ts >= ks;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bse_div.sv =====
// ----------------------------------------------------------------------------
// Ratio divider
// Signed num / den in Q2.30, truncated toward zero and saturated, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bse_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [34:0] num_i,
  input  logic signed [34:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);
  import bse_pkg::*;

  localparam int CntW = $clog2(DivSteps);

  logic        run_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic        neg_q;
  logic [34:0] rem_q;
  logic [33:0] den_q;
  logic [29:0] q_q;
  logic signed [31:0] quot_q;

  logic [34:0] un_w, ud_w;
  logic        ge_w;
  logic [34:0] diff_w;
  logic [31:0] m_w;

  assign un_w   = num_i[34] ? 35'(-num_i) : num_i;
  assign ud_w   = den_i[34] ? 35'(-den_i) : den_i;
  assign ge_w   = rem_q >= {1'b0, den_q};
  assign diff_w = ge_w ? rem_q - {1'b0, den_q} : rem_q;
  assign m_w    = {1'b0, q_q, ge_w};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        // A quotient of two or more saturates at once.
        if (un_w >= {ud_w[33:0], 1'b0}) begin
          done_q <= 1'b1;
        end else begin
          run_q <= 1'b1;
        end
      end else if (run_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivSteps - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= num_i[34] ^ den_i[34];
      rem_q  <= {1'b0, un_w[33:0]};
      den_q  <= ud_w[33:0];
      quot_q <= (num_i[34] ^ den_i[34]) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (run_q) begin
      q_q   <= {q_q[28:0], ge_w};
      rem_q <= {diff_w[33:0], 1'b0};
      if (cnt_q == CntW'(DivSteps - 1)) begin
        quot_q <= neg_q ? $signed(-m_w) : $signed(m_w);
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== rtl/bse_store.sv =====
// ----------------------------------------------------------------------------
// Knot and coefficient store
// One synchronous memory: knots first, coefficients after them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bse_store #(
  parameter int MAX_BASIS = bse_pkg::MaxBasisDef,
  parameter int MAX_ORDER = bse_pkg::MaxOrderDef,
  localparam int Depth    = 2 * MAX_BASIS + MAX_ORDER,
  localparam int AW       = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  bse_pkg::bse_in_t     item_i,
  input  logic [AW-1:0]        raddr_i,
  output logic signed [31:0]   rdata_o
);
  import bse_pkg::*;

  localparam int KnotDepth = MAX_BASIS + MAX_ORDER;

  logic signed [31:0] mem [Depth];
  logic signed [31:0] rdata_q;
  logic               wen;
  logic [AW-1:0]      waddr;

  // Writes beyond a table's depth are dropped.
  always_comb begin
    wen   = 1'b0;
    waddr = '0;
    if (we_i && item_i.opcode == OP_KNOT && int'(item_i.entry_index) < KnotDepth) begin
      wen   = 1'b1;
      waddr = AW'(int'(item_i.entry_index));
    end else if (we_i && item_i.opcode == OP_COEF &&
                 int'(item_i.entry_index) < MAX_BASIS) begin
      wen   = 1'b1;
      waddr = AW'(KnotDepth + int'(item_i.entry_index));
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[waddr] <= item_i.entry_value;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/bse_seq.sv =====
// ----------------------------------------------------------------------------
// Evaluation sequencer
// Walks the Cox-de Boor recursion over the basis memory, then sums the
// coefficient-weighted basis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bse_seq #(
  parameter int MAX_BASIS = bse_pkg::MaxBasisDef,
  parameter int MAX_ORDER = bse_pkg::MaxOrderDef,
  localparam int AW       = $clog2(2 * MAX_BASIS + MAX_ORDER)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                eval_i,
  input  logic [31:0]         query_time_i,
  input  bse_pkg::bse_cfg_t   cfg_i,
  output logic [AW-1:0]       store_raddr_o,
  input  logic signed [31:0]  store_rdata_i,
  output logic                busy_o,
  output logic                res_strobe_o,
  output bse_pkg::bse_out_t   res_o
);
  import bse_pkg::*;

  localparam int KnotDepth = MAX_BASIS + MAX_ORDER;
  localparam int IW        = $clog2(MAX_BASIS + 1);
  localparam int KW        = $clog2(MAX_ORDER + 1);
  localparam int BW        = $clog2(MAX_BASIS);
  localparam int AccW      = 35 + $clog2(MAX_BASIS);

  typedef enum logic [4:0] {
    S_IDLE, S_L0_A, S_L0_B, S_L0_C,
    S_R_A, S_R_B, S_R_C, S_R_D, S_R_E, S_R_F,
    S_DIV_HI, S_ADD_HI, S_TERM_LO, S_DIV_LO, S_ADD_LO, S_WR,
    S_SUM_A, S_SUM_B, S_SUM_C, S_DONE
  } state_e;

  state_e          state_q;
  logic [IW-1:0]   i_q, n_q;
  logic [KW-1:0]   k_q, ord_q;
  logic            strobe_q;
  bse_out_t        res_q;

  logic [31:0]        t_q;
  logic signed [31:0] lo_q, k1_q, kk_q, hi_q, bi_q, bi1_q;
  logic signed [34:0] nv_q;
  logic signed [33:0] prod_q;
  logic signed [AccW-1:0] acc_q;

  logic signed [31:0] basis_mem [MAX_BASIS];
  logic signed [31:0] b_rdata_q;
  logic               b_we;
  logic [BW-1:0]      b_waddr, b_raddr;
  logic signed [31:0] b_wdata;

  logic               div_start, div_done;
  logic signed [34:0] div_num, div_den;
  logic signed [31:0] div_quot;

  logic signed [34:0] t35, lo35, k135, kk35, hi35;
  logic               last_i, next_in, in_span, out_rng;
  logic [IW-1:0]      i_nx;
  logic [IW-1:0]      n_d;
  logic [KW-1:0]      ord_d;

  assign t35  = $signed({3'b000, t_q});
  assign lo35 = 35'(lo_q);
  assign k135 = 35'(k1_q);
  assign kk35 = 35'(kk_q);
  assign hi35 = 35'(hi_q);

  assign i_nx    = i_q + IW'(1);
  assign last_i  = i_q == n_q - IW'(1);
  assign next_in = i_nx < n_q;
  assign in_span = t_ge(t_q, lo_q) && !t_ge(t_q, hi_q);
  assign out_rng = query_time_i <= {cfg_i.lower_year, 16'h0000} ||
                   query_time_i >  {cfg_i.upper_year, 16'h0000};

  // Counts of zero act as one; counts above the tables act as the maximum.
  always_comb begin
    if (cfg_i.basis_count == '0) begin
      n_d = IW'(1);
    end else if (int'(cfg_i.basis_count) > MAX_BASIS) begin
      n_d = IW'(MAX_BASIS);
    end else begin
      n_d = IW'(int'(cfg_i.basis_count));
    end
    if (cfg_i.spline_order == '0) begin
      ord_d = KW'(1);
    end else if (int'(cfg_i.spline_order) > MAX_ORDER) begin
      ord_d = KW'(MAX_ORDER);
    end else begin
      ord_d = KW'(int'(cfg_i.spline_order));
    end
  end

  always_comb begin
    store_raddr_o = '0;
    b_raddr       = '0;
    b_we          = 1'b0;
    b_waddr       = BW'(i_q);
    b_wdata       = '0;
    div_start     = 1'b0;
    div_num       = t35 - lo35;
    div_den       = kk35 - lo35;
    unique case (state_q)
      S_L0_A: store_raddr_o = AW'(i_q);
      S_L0_B: store_raddr_o = AW'(i_nx);
      S_L0_C: begin
        b_we    = 1'b1;
        b_wdata = (t_ge(t_q, lo_q) && !t_ge(t_q, store_rdata_i)) ? Q30One : '0;
      end
      S_R_A: store_raddr_o = AW'(i_q);
      S_R_B: store_raddr_o = AW'(i_nx);
      S_R_C: store_raddr_o = AW'(i_q) + AW'(k_q);
      S_R_D: begin
        store_raddr_o = AW'(i_q) + AW'(k_q) + AW'(1);
        b_raddr       = BW'(i_q);
      end
      S_R_E: b_raddr = next_in ? BW'(i_nx) : BW'(i_q);
      S_R_F: begin
        div_num   = hi35 - t35;
        div_den   = hi35 - k135;
        div_start = in_span && (hi_q != k1_q);
      end
      S_TERM_LO: div_start = kk_q != lo_q;
      S_WR: begin
        b_we    = 1'b1;
        b_wdata = sat32(64'(nv_q));
      end
      S_SUM_A: begin
        store_raddr_o = AW'(KnotDepth) + AW'(i_q);
        b_raddr       = BW'(i_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      basis_mem[b_waddr] <= b_wdata;
    end
    b_rdata_q <= basis_mem[b_raddr];
  end

  bse_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      i_q      <= '0;
      k_q      <= '0;
      n_q      <= IW'(1);
      ord_q    <= KW'(1);
      strobe_q <= 1'b0;
      res_q    <= '0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (eval_i) begin
            if (out_rng) begin
              strobe_q <= 1'b1;
              res_q    <= '{spline_value: '0, out_of_range: 1'b1};
            end else begin
              n_q     <= n_d;
              ord_q   <= ord_d;
              i_q     <= '0;
              state_q <= S_L0_A;
            end
          end
        end
        S_L0_A: state_q <= S_L0_B;
        S_L0_B: state_q <= S_L0_C;
        S_L0_C: begin
          if (last_i) begin
            i_q     <= '0;
            k_q     <= KW'(1);
            state_q <= (ord_q == KW'(1)) ? S_SUM_A : S_R_A;
          end else begin
            i_q     <= i_nx;
            state_q <= S_L0_A;
          end
        end
        S_R_A: state_q <= S_R_B;
        S_R_B: state_q <= S_R_C;
        S_R_C: state_q <= S_R_D;
        S_R_D: state_q <= S_R_E;
        S_R_E: state_q <= S_R_F;
        S_R_F: begin
          if (!in_span) begin
            state_q <= S_WR;
          end else if (hi_q != k1_q) begin
            state_q <= S_DIV_HI;
          end else begin
            state_q <= S_TERM_LO;
          end
        end
        S_DIV_HI: if (div_done) state_q <= S_ADD_HI;
        S_ADD_HI: state_q <= S_TERM_LO;
        S_TERM_LO: state_q <= (kk_q != lo_q) ? S_DIV_LO : S_WR;
        S_DIV_LO: if (div_done) state_q <= S_ADD_LO;
        S_ADD_LO: state_q <= S_WR;
        S_WR: begin
          if (last_i) begin
            i_q <= '0;
            if (k_q == ord_q - KW'(1)) begin
              state_q <= S_SUM_A;
            end else begin
              k_q     <= k_q + KW'(1);
              state_q <= S_R_A;
            end
          end else begin
            i_q     <= i_nx;
            state_q <= S_R_A;
          end
        end
        S_SUM_A: state_q <= S_SUM_B;
        S_SUM_B: state_q <= S_SUM_C;
        S_SUM_C: begin
          if (last_i) begin
            state_q <= S_DONE;
          end else begin
            i_q     <= i_nx;
            state_q <= S_SUM_A;
          end
        end
        S_DONE: begin
          strobe_q <= 1'b1;
          res_q    <= '{spline_value: sat32(64'(acc_q)), out_of_range: 1'b0};
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && eval_i) begin
      t_q <= query_time_i;
    end
    if (state_q == S_L0_B || state_q == S_R_B) begin
      lo_q <= store_rdata_i;
    end
    if (state_q == S_R_C) begin
      k1_q <= store_rdata_i;
    end
    if (state_q == S_R_D) begin
      kk_q <= store_rdata_i;
    end
    if (state_q == S_R_E) begin
      hi_q <= store_rdata_i;
      bi_q <= b_rdata_q;
    end
    if (state_q == S_R_F) begin
      bi1_q <= next_in ? b_rdata_q : '0;
      nv_q  <= '0;
    end
    if (state_q == S_DIV_HI && div_done) begin
      prod_q <= mul_q30(div_quot, bi1_q);
    end
    if (state_q == S_DIV_LO && div_done) begin
      prod_q <= mul_q30(div_quot, bi_q);
    end
    if (state_q == S_ADD_HI || state_q == S_ADD_LO) begin
      nv_q <= nv_q + 35'(prod_q);
    end
    if (state_q == S_SUM_B) begin
      prod_q <= mul_q30(store_rdata_i, b_rdata_q);
    end
    if (state_q == S_SUM_C) begin
      acc_q <= acc_q + AccW'(prod_q);
    end else if (state_q == S_L0_C || state_q == S_WR) begin
      acc_q <= '0;
    end
  end

  assign busy_o       = state_q != S_IDLE;
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

`default_nettype wire

// ===== rtl/bspline_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// B-spline evaluator core
// Knot and coefficient tables with Cox-de Boor evaluation in fixed point.
// ----------------------------------------------------------------------------
// Channel   Ports                                   Direction
// request   start_i, busy_o, req_i                  in
// result    res_strobe_o, res_o                     out
// config    cfg_we_i, cfg_idx_i, cfg_data_i         in
//
// Table writes never raise busy. An out-of-range evaluate answers in the next
// cycle without raising busy. An in-range evaluate raises busy; each recursion
// step runs up to two ratio divisions, and a ratio that saturates finishes its
// division without the divider's bit-by-bit steps.
// Reset restores the register defaults; table contents stay undefined until
// written. Results are held one cycle and the receiver cannot stall them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bspline_evaluator_core #(
  parameter int MAX_BASIS = bse_pkg::MaxBasisDef,
  parameter int MAX_ORDER = bse_pkg::MaxOrderDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  bse_pkg::bse_in_t              req_i,
  output logic                          res_strobe_o,
  output bse_pkg::bse_out_t             res_o,
  input  logic                          cfg_we_i,
  input  logic [bse_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bse_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bse_pkg::*;

  localparam int AW = $clog2(2 * MAX_BASIS + MAX_ORDER);

  bse_cfg_t           cfg_q;
  logic               accept, eval_go;
  logic [AW-1:0]      store_raddr;
  logic signed [31:0] store_rdata;

  assign accept  = start_i && !busy_o;
  assign eval_go = accept && req_i.opcode == OP_EVAL;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{basis_count: BasisCountRst, spline_order: SplineOrderRst,
                 lower_year: LowerYearRst, upper_year: UpperYearRst};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BASIS_COUNT:  cfg_q.basis_count  <= cfg_data_i[5:0];
        CFG_SPLINE_ORDER: cfg_q.spline_order <= cfg_data_i[3:0];
        CFG_LOWER_YEAR:   cfg_q.lower_year   <= cfg_data_i;
        CFG_UPPER_YEAR:   cfg_q.upper_year   <= cfg_data_i;
      endcase
    end
  end

  bse_store #(.MAX_BASIS(MAX_BASIS), .MAX_ORDER(MAX_ORDER)) u_store (
    .clk_i   (clk_i),
    .we_i    (accept),
    .item_i  (req_i),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  bse_seq #(.MAX_BASIS(MAX_BASIS), .MAX_ORDER(MAX_ORDER)) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .eval_i        (eval_go),
    .query_time_i  (req_i.query_time),
    .cfg_i         (cfg_q),
    .store_raddr_o (store_raddr),
    .store_rdata_i (store_rdata),
    .busy_o        (busy_o),
    .res_strobe_o  (res_strobe_o),
    .res_o         (res_o)
  );

endmodule

`default_nettype wire

// ===== rtl/bse_checker.sv =====
// ----------------------------------------------------------------------------
// B-spline evaluator port checker
// Checks result and busy behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bse_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input bse_pkg::bse_in_t              req_i,
  input logic                          res_strobe_o,
  input bse_pkg::bse_out_t             res_o,
  input logic                          cfg_we_i,
  input logic [bse_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input logic [bse_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bse_pkg::*;

  // Table writes never produce a result.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_i.opcode == OP_KNOT || req_i.opcode == OP_COEF)
    |=> !res_strobe_o)
    else $error("result after table write");

  // An evaluate either answers at once or starts working.
  a_eval_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_i.opcode == OP_EVAL |=> busy_o || res_strobe_o)
    else $error("evaluate request lost");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> !busy_o)
    else $error("result while busy");

  a_busy_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> res_strobe_o && !res_o.out_of_range)
    else $error("evaluation ended without result");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.out_of_range |-> res_o.spline_value == 32'sd0)
    else $error("out-of-range result not zero");

endmodule

bind bspline_evaluator_core bse_checker u_bse_checker (.*);

`default_nettype wire

// ===== test/tb_bspline_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// B-spline evaluator core testbench
// Fills the knot and coefficient tables, then sends directed and random
// requests under several register settings. A mirror of the tables and the
// fixed-point Cox-de Boor recursion predicts every result, and a checker
// compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bspline_evaluator_core;
  import bse_pkg::*;

  localparam int KnotDepth = MaxBasisDef + MaxOrderDef;
  localparam longint Q30Max = 64'sd2147483647;
  localparam longint Q30Min = -64'sd2147483648;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  bse_in_t     req_i;
  logic        res_strobe_o;
  bse_out_t    res_o;
  logic        cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  bspline_evaluator_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_i        (req_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Mirror of the block's state.
  longint      knot_mirror [KnotDepth];
  longint      coef_mirror [MaxBasisDef];
  logic [5:0]  basis_count_r;
  logic [3:0]  spline_order_r;
  logic [15:0] lower_year_r;
  logic [15:0] upper_year_r;

  bse_out_t expected_q[$];
  int       err_cnt;
  int       items_sent;
  int       evals_checked;
  int       out_of_range_seen;
  int       settings_run;
  bit       no_idle;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic longint magnitude(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sat_q30(input longint v);
    if (v > Q30Max) return Q30Max;
    if (v < Q30Min) return Q30Min;
    return v;
  endfunction

  // Quotient in Q2.30, truncated toward zero and saturated.
  function automatic longint divide_q30(input longint num, input longint den);
    bit              neg;
    longint unsigned un, ud, q, r;
    longint          m;
    neg = (num < 0) != (den < 0);
    un  = magnitude(num);
    ud  = magnitude(den);
    q   = un / ud;
    r   = un % ud;
    if (q >= 2) return neg ? Q30Min : Q30Max;
    m = longint'((q << 30) + ((r << 30) / ud));
    return neg ? -m : m;
  endfunction

  function automatic longint product_q30(input longint a, input longint b);
    bit              neg;
    longint unsigned p;
    longint          m;
    neg = (a < 0) != (b < 0);
    p   = longint'(magnitude(a)) * longint'(magnitude(b));
    m   = longint'(p >> 30);
    return neg ? -m : m;
  endfunction

  function automatic bse_out_t predict_spline(input logic [31:0] query);
    bse_out_t r;
    longint   t, lo, hi, nv, d0, d1, nb, acc;
    longint   basis [MaxBasisDef];
    int       n, order;
    t = longint'({32'd0, query});
    r.spline_value = '0;
    r.out_of_range = 1'b0;
    if (t <= (longint'(lower_year_r) << 16) || t > (longint'(upper_year_r) << 16)) begin
      r.out_of_range = 1'b1;
      return r;
    end
    n = int'(basis_count_r);
    if (n < 1) n = 1;
    if (n > MaxBasisDef) n = MaxBasisDef;
    order = int'(spline_order_r);
    if (order < 1) order = 1;
    if (order > MaxOrderDef) order = MaxOrderDef;
    for (int i = 0; i < n; i++) begin
      basis[i] = (t >= knot_mirror[i] && t < knot_mirror[i+1]) ? (64'sd1 << 30) : 0;
    end
    for (int k = 1; k < order; k++) begin
      for (int i = 0; i < n; i++) begin
        lo = knot_mirror[i];
        hi = knot_mirror[i+k+1];
        nv = 0;
        if (t >= lo && t < hi) begin
          d1 = hi - knot_mirror[i+1];
          if (d1 != 0) begin
            // The row past the last basis function reads as zero.
            nb = (i + 1 < n) ? basis[i+1] : 0;
            nv += product_q30(divide_q30(hi - t, d1), nb);
          end
          d0 = knot_mirror[i+k] - lo;
          if (d0 != 0) nv += product_q30(divide_q30(t - lo, d0), basis[i]);
          nv = sat_q30(nv);
        end
        basis[i] = nv;
      end
    end
    acc = 0;
    for (int i = 0; i < n; i++) acc += product_q30(coef_mirror[i], basis[i]);
    r.spline_value = 32'(sat_q30(acc));
    return r;
  endfunction

  always @(posedge clk_i) begin
    bse_out_t exp_r;
    if (rst_ni && res_strobe_o) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %h oor %b",
                                  res_o.spline_value, res_o.out_of_range));
      end else begin
        exp_r = expected_q.pop_front();
        evals_checked++;
        if (exp_r.out_of_range) out_of_range_seen++;
        if (res_o.spline_value !== exp_r.spline_value)
          report_mismatch($sformatf("spline_value %h, predicted %h",
                                    res_o.spline_value, exp_r.spline_value));
        if (res_o.out_of_range !== exp_r.out_of_range)
          report_mismatch($sformatf("out_of_range %b, predicted %b",
                                    res_o.out_of_range, exp_r.out_of_range));
      end
    end
  end

  // Sends one request and updates the mirror once it has been accepted.
  task automatic send_item(input bse_in_t it);
    int gap;
    if (!no_idle && $urandom_range(0, 99) < 34) begin
      start_i <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= it;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
    case (op_e'(it.opcode))
      OP_EVAL: expected_q.push_back(predict_spline(it.query_time));
      OP_KNOT: if (it.entry_index < KnotDepth) knot_mirror[it.entry_index] = it.entry_value;
      OP_COEF: if (it.entry_index < MaxBasisDef) coef_mirror[it.entry_index] = it.entry_value;
      default: ;
    endcase
  endtask

  task automatic send_op(input op_e op, input int idx, input logic [31:0] val,
                         input logic [31:0] query);
    bse_in_t it;
    it.opcode      = op;
    it.entry_index = 6'(idx);
    it.entry_value = val;
    it.query_time  = query;
    send_item(it);
  endtask

  // Lets the block run empty: all results in and nothing in flight.
  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_BASIS_COUNT:  basis_count_r  = data[5:0];
      CFG_SPLINE_ORDER: spline_order_r = data[3:0];
      CFG_LOWER_YEAR:   lower_year_r   = data;
      CFG_UPPER_YEAR:   upper_year_r   = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input int n, input int k, input int lo, input int up);
    wait_idle();
    write_reg(CFG_BASIS_COUNT, 16'(n));
    write_reg(CFG_SPLINE_ORDER, 16'(k));
    write_reg(CFG_LOWER_YEAR, 16'(lo));
    write_reg(CFG_UPPER_YEAR, 16'(up));
    settings_run++;
  endtask

  // Ascending knots from a base year, with some repeated knots.
  task automatic load_knot_grid(input int base_year, input int span, input bit repeats);
    longint v;
    v = longint'(base_year) << 16;
    for (int i = 0; i < KnotDepth; i++) begin
      send_op(OP_KNOT, i, 32'(v), $urandom);
      if (!(repeats && $urandom_range(0, 4) == 0)) v += span + $urandom_range(0, span / 4);
    end
  endtask

  task automatic load_coefs();
    for (int i = 0; i < MaxBasisDef; i++) begin
      case ($urandom_range(0, 5))
        0: send_op(OP_COEF, i, 32'h7FFF_FFFF, $urandom);
        1: send_op(OP_COEF, i, 32'h8000_0000, $urandom);
        2: send_op(OP_COEF, i, $urandom, $urandom);
        default: send_op(OP_COEF, i, 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000),
                         $urandom);
      endcase
    end
  endtask

  function automatic logic [31:0] pick_query();
    int          j;
    logic [31:0] lo_t, up_t;
    lo_t = {lower_year_r, 16'd0};
    up_t = {upper_year_r, 16'd0};
    j = $urandom_range(0, KnotDepth - 2);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return lo_t + 32'($urandom_range(0, 1));
      2: return up_t + 32'($urandom_range(0, 1));
      3: return 32'(knot_mirror[j]);
      default: return 32'(knot_mirror[j]) +
                      32'($urandom % (32'(knot_mirror[j+1] - knot_mirror[j]) | 32'd1));
    endcase
  endfunction

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_op(OP_EVAL, $urandom_range(0, 63), $urandom, pick_query());
    end else if (pick < 60) begin
      // Nudge one knot, mostly keeping the sequence close to ascending.
      send_op(OP_KNOT, $urandom_range(0, 45),
              ($urandom_range(0, 9) == 0) ? $urandom
              : 32'(knot_mirror[$urandom_range(0, KnotDepth - 1)]) + 32'($urandom_range(0, 4096)),
              $urandom);
    end else if (pick < 92) begin
      send_op(OP_COEF, $urandom_range(0, 40), $urandom, $urandom);
    end else begin
      send_op(OP_RSVD, $urandom_range(0, 63), $urandom, $urandom);
    end
  endtask

  task automatic run_setting(input int n, input int k, input int lo, input int up,
                             input int count);
    apply_setting(n, k, lo, up);
    load_knot_grid(lo + $urandom_range(0, 2), $urandom_range(32'h2000, 32'h30000),
                   $urandom_range(0, 1));
    load_coefs();
    repeat (count) random_item();
  endtask

  task automatic test_table_fill();
    for (int i = 0; i < KnotDepth; i++) send_op(OP_KNOT, i, 32'((10 + i) << 16), $urandom);
    for (int i = 0; i < MaxBasisDef; i++) send_op(OP_COEF, i, 32'((i + 1) << 16), $urandom);
  endtask

  task automatic test_directed();
    send_op(OP_EVAL, 0, 0, 32'd0);             // at the lower bound
    send_op(OP_EVAL, 0, 0, 32'd1);             // in range, before the first knot
    send_op(OP_EVAL, 0, 0, 32'h000C_8000);
    send_op(OP_EVAL, 0, 0, 32'h000D_0000);     // exactly on a knot
    send_op(OP_EVAL, 0, 0, 32'hFFFF_FFFF);     // above the upper bound
    send_op(OP_EVAL, 0, 0, 32'hFFFF_0000);     // equal to the upper bound
    send_op(OP_KNOT, 40, 32'h1234_5678, 0);    // beyond the knot table
    send_op(OP_COEF, 32, 32'h1234_5678, 0);    // beyond the coefficient table
    send_op(OP_RSVD, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_EVAL, 0, 0, 32'h000C_8000);
    send_op(OP_KNOT, 14, 32'h000D_0000, 0);    // below the knot before it
    send_op(OP_EVAL, 0, 0, 32'h000D_4000);
    send_op(OP_COEF, 2, 32'h7FFF_FFFF, 0);
    send_op(OP_COEF, 3, 32'h7FFF_FFFF, 0);
    send_op(OP_EVAL, 0, 0, 32'h000D_8000);
    send_op(OP_KNOT, 15, 32'h8000_0000, 0);    // unsorted knots
    send_op(OP_EVAL, 0, 0, 32'h000D_8000);
    send_op(OP_KNOT, 16, 32'h7FFF_FFFF, 0);
    send_op(OP_COEF, 4, 32'h8000_0000, 0);
    send_op(OP_EVAL, 0, 0, 32'h000E_0000);
    send_op(OP_EVAL, 0, 0, 32'h7FFF_0000);
  endtask

  task automatic test_register_extremes();
    run_setting(0, 0, 0, 65535, 20);           // zero counts act as one
    run_setting(1, 1, 5, 6, 20);
    run_setting(63, 15, 0, 65535, 8);          // clamped to the largest sizes
    run_setting(32, 2, 3, 400, 20);
    run_setting(4, 8, 0, 65535, 20);
    run_setting(8, 4, 65535, 65535, 20);       // nothing is in range
    run_setting(8, 4, 0, 0, 20);
  endtask

  task automatic test_drain_pause();
    run_setting(5, 3, 20, 120, 40);
    wait_idle();
    repeat (40) random_item();
  endtask

  task automatic test_no_idle();
    no_idle = 1'b1;
    run_setting(3, 3, 10, 200, 120);
    no_idle = 1'b0;
  endtask

  task automatic test_random_settings();
    int n, k, lo, up;
    while (items_sent < 1800) begin
      n  = $urandom_range(0, 8);
      k  = $urandom_range(0, 5);
      lo = $urandom_range(0, 200);
      up = ($urandom_range(0, 4) == 0) ? 65535 : lo + $urandom_range(0, 300);
      run_setting(n, k, lo, up, $urandom_range(40, 120));
    end
  endtask

  initial begin
    int guard;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    req_i      = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    err_cnt = 0;
    items_sent = 0;
    evals_checked = 0;
    out_of_range_seen = 0;
    settings_run = 0;
    no_idle = 1'b0;
    basis_count_r  = BasisCountRst;
    spline_order_r = SplineOrderRst;
    lower_year_r   = LowerYearRst;
    upper_year_r   = UpperYearRst;
    for (int i = 0; i < KnotDepth; i++) knot_mirror[i] = 0;
    for (int i = 0; i < MaxBasisDef; i++) coef_mirror[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_table_fill();
    test_directed();
    test_register_extremes();
    test_drain_pause();
    test_no_idle();
    test_random_settings();

    start_i <= 1'b0;
    guard = 0;
    while (expected_q.size() != 0 && guard < 100_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", expected_q.size()));

    $display("covered %0d requests under %0d register settings", items_sent, settings_run);
    $display("checked %0d evaluations, %0d of them out of range", evals_checked,
             out_of_range_seen);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
